FILE: rtl/ffzg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffzg_pkg
// Types and codes shared by the five-finger zoom gesture detector.
// ----------------------------------------------------------------------------
package ffzg_pkg;

	// Event kinds
	localparam logic [2:0] FUNC_DOWN   = 3'd0;
	localparam logic [2:0] FUNC_MOTION = 3'd1;
	localparam logic [2:0] FUNC_UP     = 3'd2;
	localparam logic [2:0] FUNC_FRAME  = 3'd3;
	localparam logic [2:0] FUNC_CANCEL = 3'd4;

	// Result status codes
	localparam logic [2:0] ST_IGNORE    = 3'd0;
	localparam logic [2:0] ST_MAYBE     = 3'd1;
	localparam logic [2:0] ST_UPDATE    = 3'd2;
	localparam logic [2:0] ST_FINISHED  = 3'd3;
	localparam logic [2:0] ST_CANCELLED = 3'd4;

	// Zoom directions
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_IN   = 2'd1;
	localparam logic [1:0] DIR_OUT  = 2'd2;

	// Finger count saturates here
	localparam logic [3:0] COUNT_MAX = 4'd15;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_THR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_THR = 2'd1;

	localparam logic [15:0] THR_RESET = 16'd320;

	typedef struct packed {
		logic [2:0]  func;
		logic [3:0]  slot;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
	} evt_t;

	typedef struct packed {
		logic [2:0] status;
		logic [1:0] direction;
		logic [1:0] overall_direction;
	} res_t;

endpackage
`default_nettype wire

FILE: rtl/ffzg_spread.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffzg_spread
// Sum of Manhattan distances from finger 0 to every other finger.
// ----------------------------------------------------------------------------
module ffzg_spread #(
	parameter int FINGERS    = 5,
	parameter int COORD_BITS = 16,
	parameter int SUM_W      = 19
) (
	input  wire logic [COORD_BITS-1:0] px [FINGERS],
	input  wire logic [COORD_BITS-1:0] py [FINGERS],
	output logic      [SUM_W-1:0]      sum
);

	localparam int PAIR_W = COORD_BITS + 1;

	logic [PAIR_W-1:0] span [FINGERS];

	// Per-finger distance, all independent
	always_comb begin
		span[0] = '0;
		for (int i = 1; i < FINGERS; i++) begin
			span[i] = PAIR_W'((px[0] >= px[i]) ? (px[0] - px[i]) : (px[i] - px[0]))
				+ PAIR_W'((py[0] >= py[i]) ? (py[0] - py[i]) : (py[i] - py[0]));
		end
	end

	always_comb begin
		sum = '0;
		for (int i = 1; i < FINGERS; i++) begin
			sum = sum + SUM_W'(span[i]);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/ffzg_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffzg_core
// Gesture state, per-event next-state logic and result decode.
// ----------------------------------------------------------------------------
module ffzg_core #(
	parameter int FINGERS    = 5,
	parameter int COORD_BITS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire ffzg_pkg::evt_t  evt,
	input  wire logic [15:0]     step_thr,
	input  wire logic [15:0]     total_thr,
	output ffzg_pkg::res_t       res
);

	localparam int KEEP_W = (COORD_BITS < 16) ? COORD_BITS : 16;
	localparam int SUM_W  = COORD_BITS + $clog2(2 * (FINGERS - 1));
	localparam int LIM_W  = 16 + $clog2(FINGERS);
	localparam int CMP_W  = ((SUM_W > LIM_W) ? SUM_W : LIM_W) + 1;
	localparam logic [3:0] FCNT = 4'(FINGERS);

	logic [3:0]            cnt_q, cnt_n;
	logic                  started_q, started_n;
	logic                  canc_q, canc_n;
	logic [1:0]            dir_q, dir_n;
	logic [COORD_BITS-1:0] sx_q [FINGERS], sy_q [FINGERS], sx_n [FINGERS], sy_n [FINGERS];
	logic [COORD_BITS-1:0] lx_q [FINGERS], ly_q [FINGERS], lx_n [FINGERS], ly_n [FINGERS];
	logic [COORD_BITS-1:0] cx_q [FINGERS], cy_q [FINGERS], cx_n [FINGERS], cy_n [FINGERS];
	logic                  end_reset;
	logic [2:0]            status;
	logic [COORD_BITS-1:0] px, py;

	logic [SUM_W-1:0]        sp_cur_q, sp_last_q, sp_cur_n, sp_start_n;
	logic signed [CMP_W-1:0] step_delta, step_mag, step_lim;
	logic signed [CMP_W-1:0] tot_delta, tot_lim;

	assign px = COORD_BITS'(evt.pos_x[KEEP_W-1:0]);
	assign py = COORD_BITS'(evt.pos_y[KEEP_W-1:0]);

	ffzg_spread #(.FINGERS(FINGERS), .COORD_BITS(COORD_BITS), .SUM_W(SUM_W)) u_sp_cur_q (
		.px(cx_q), .py(cy_q), .sum(sp_cur_q)
	);
	ffzg_spread #(.FINGERS(FINGERS), .COORD_BITS(COORD_BITS), .SUM_W(SUM_W)) u_sp_last_q (
		.px(lx_q), .py(ly_q), .sum(sp_last_q)
	);
	ffzg_spread #(.FINGERS(FINGERS), .COORD_BITS(COORD_BITS), .SUM_W(SUM_W)) u_sp_cur_n (
		.px(cx_n), .py(cy_n), .sum(sp_cur_n)
	);
	ffzg_spread #(.FINGERS(FINGERS), .COORD_BITS(COORD_BITS), .SUM_W(SUM_W)) u_sp_start_n (
		.px(sx_n), .py(sy_n), .sum(sp_start_n)
	);

	// Frame test: change of spread against (FINGERS-1) * step threshold
	assign step_delta = CMP_W'(sp_cur_q) - CMP_W'(sp_last_q);
	assign step_mag   = step_delta[CMP_W-1] ? -step_delta : step_delta;
	assign step_lim   = CMP_W'(FINGERS - 1) * CMP_W'(step_thr);

	always_comb begin
		cnt_n     = cnt_q;
		started_n = started_q;
		canc_n    = canc_q;
		dir_n     = dir_q;
		sx_n      = sx_q;
		sy_n      = sy_q;
		lx_n      = lx_q;
		ly_n      = ly_q;
		cx_n      = cx_q;
		cy_n      = cy_q;
		end_reset = 1'b0;
		status    = ffzg_pkg::ST_IGNORE;
		unique case (evt.func)
			ffzg_pkg::FUNC_DOWN: begin
				cnt_n = (cnt_q != ffzg_pkg::COUNT_MAX) ? cnt_q + 4'd1 : cnt_q;
				if (!canc_q) begin
					if (cnt_n <= FCNT) begin
						for (int i = 0; i < FINGERS; i++) begin
							if (evt.slot == 4'(i)) begin
								sx_n[i] = px;
								sy_n[i] = py;
							end
						end
					end
					if (cnt_n == FCNT) begin
						started_n = 1'b1;
						lx_n      = sx_n;
						ly_n      = sy_n;
						cx_n      = sx_n;
						cy_n      = sy_n;
						status    = ffzg_pkg::ST_MAYBE;
					end else if (cnt_n > FCNT) begin
						canc_n = 1'b1;
						status = ffzg_pkg::ST_CANCELLED;
					end
				end
			end
			ffzg_pkg::FUNC_MOTION: begin
				if (!canc_q && started_q) begin
					for (int i = 0; i < FINGERS; i++) begin
						if (evt.slot == 4'(i)) begin
							cx_n[i] = px;
							cy_n[i] = py;
						end
					end
				end
			end
			ffzg_pkg::FUNC_UP: begin
				cnt_n = (cnt_q != 4'd0) ? cnt_q - 4'd1 : cnt_q;
				if (cnt_n == 4'd0) begin
					if (!canc_q && started_q && dir_q != ffzg_pkg::DIR_NONE) begin
						status = ffzg_pkg::ST_FINISHED;
					end
					end_reset = 1'b1;
				end
			end
			ffzg_pkg::FUNC_FRAME: begin
				if (!canc_q && started_q && step_mag >= step_lim) begin
					lx_n   = cx_q;
					ly_n   = cy_q;
					dir_n  = (step_delta > 0) ? ffzg_pkg::DIR_IN : ffzg_pkg::DIR_OUT;
					status = ffzg_pkg::ST_UPDATE;
				end
			end
			ffzg_pkg::FUNC_CANCEL: begin
				canc_n = 1'b1;
				status = ffzg_pkg::ST_CANCELLED;
			end
			default: begin
			end
		endcase
	end

	// Overall direction from the post-event points, before any end reset
	assign tot_delta = CMP_W'(sp_cur_n) - CMP_W'(sp_start_n);
	assign tot_lim   = CMP_W'(FINGERS - 1) * CMP_W'(total_thr);

	always_comb begin
		res.status    = status;
		res.direction = dir_n;
		if (!started_n || canc_n) begin
			res.overall_direction = ffzg_pkg::DIR_NONE;
		end else if (tot_delta > tot_lim) begin
			res.overall_direction = ffzg_pkg::DIR_IN;
		end else if (tot_delta < -tot_lim) begin
			res.overall_direction = ffzg_pkg::DIR_OUT;
		end else begin
			res.overall_direction = ffzg_pkg::DIR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			started_q <= 1'b0;
			canc_q    <= 1'b0;
			dir_q     <= ffzg_pkg::DIR_NONE;
			for (int i = 0; i < FINGERS; i++) begin
				sx_q[i] <= '0;
				sy_q[i] <= '0;
				lx_q[i] <= '0;
				ly_q[i] <= '0;
				cx_q[i] <= '0;
				cy_q[i] <= '0;
			end
		end else if (step) begin
			cnt_q <= cnt_n;
			if (end_reset) begin
				started_q <= 1'b0;
				canc_q    <= 1'b0;
				dir_q     <= ffzg_pkg::DIR_NONE;
				for (int i = 0; i < FINGERS; i++) begin
					sx_q[i] <= '0;
					sy_q[i] <= '0;
					lx_q[i] <= '0;
					ly_q[i] <= '0;
					cx_q[i] <= '0;
					cy_q[i] <= '0;
				end
			end else begin
				started_q <= started_n;
				canc_q    <= canc_n;
				dir_q     <= dir_n;
				sx_q      <= sx_n;
				sy_q      <= sy_n;
				lx_q      <= lx_n;
				ly_q      <= ly_n;
				cx_q      <= cx_n;
				cy_q      <= cy_n;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/five_finger_zoom_gesture_detector_unit.sv
`default_nettype none
// Pipeline: an event passes through the input register, then the result register, and its
//   result is offered once it is in the result register; one event per cycle is sustained
//   while the result channel is not stalled, since the gesture state update, the spread sums
//   and the result decode all fit between those two registers.
// Reset: arst_n clears the finger count, flags, direction and all stored points, and
//   loads both thresholds with 320; the input stage comes out of reset empty and does not stall.
// ----------------------------------------------------------------------------
// five_finger_zoom_gesture_detector_unit
// Recognizes a five-finger pinch zoom from a stream of touch events and
// reports one status/direction result per event.
// ----------------------------------------------------------------------------
module five_finger_zoom_gesture_detector_unit #(
	parameter int FINGERS    = 5,
	parameter int COORD_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// event channel
	input  wire logic                               evt_valid,
	output logic                                    evt_stall,
	input  wire ffzg_pkg::evt_t                     evt,
	// result channel
	output logic                                    res_valid,
	input  wire logic                               res_stall,
	output ffzg_pkg::res_t                          res,
	// configuration write channel
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [ffzg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [15:0]                        cfg_data
);

	ffzg_pkg::evt_t evt_s1;
	logic           valid_s1;
	ffzg_pkg::res_t res_q;
	logic           res_valid_q;
	ffzg_pkg::res_t core_res;
	logic [15:0]    step_thr_q;
	logic [15:0]    total_thr_q;
	logic           advance;
	logic           step;

	// The result register moves when it is empty or its transfer completes.
	assign advance   = !res_valid_q || !res_stall;
	// Hold the input stage only while a finished item cannot move on.
	assign evt_stall = valid_s1 && !advance;
	// The event in the input stage is committed as it moves into the result register.
	assign step      = valid_s1 && advance;

	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign cfg_ready = 1'b1;

	// Input register: take a new event whenever the stage is not held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!evt_stall) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && !evt_stall) begin
			evt_s1 <= evt;
		end
	end

	ffzg_core #(
		.FINGERS   (FINGERS),
		.COORD_BITS(COORD_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.evt      (evt_s1),
		.step_thr (step_thr_q),
		.total_thr(total_thr_q),
		.res      (core_res)
	);

	// Result register: advance on an empty slot or a completed transfer, else hold.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= core_res;
		end
	end

	// Threshold registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_thr_q  <= ffzg_pkg::THR_RESET;
			total_thr_q <= ffzg_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ffzg_pkg::REG_STEP_THR:  step_thr_q  <= cfg_data;
				ffzg_pkg::REG_TOTAL_THR: total_thr_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire
